// ----- rtl/banked_register_and_buffer_port_core_macros.svh -----
// Assertion macros for the banked register and buffer port core.
`ifndef BANKED_REGISTER_AND_BUFFER_PORT_CORE_MACROS_SVH
`define BANKED_REGISTER_AND_BUFFER_PORT_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge out of reset.
`define BRBP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("brbp assertion failed");

// Condition that must hold in the cycle after a trigger.
`define BRBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brbp assertion failed");

`else

`define BRBP_ASSERT(label, expr)
`define BRBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/brbp_pkg.sv -----
// Shared types, sizes and codes for the banked register and buffer port core.
package brbp_pkg;

  // Packet memory depth; a power of two, so pointer wrap and reduction are masks.
  localparam int BUFFER_DEPTH = 8192;
  localparam int BANK_COUNT   = 4;

  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int DATA_W       = 8;
  localparam int ADDR_W       = 5;
  localparam int BANK_W       = 2;
  localparam int REG_AW       = BANK_W + ADDR_W;
  localparam int REG_DEPTH    = 1 << REG_AW;
  localparam int SHARED_COUNT = 5;
  localparam int SH_IW        = $clog2(SHARED_COUNT);

  // Register addresses with a fixed role.
  localparam logic [ADDR_W-1:0] ADDR_PTR_END = 5'h04;
  localparam logic [ADDR_W-1:0] ADDR_RP_END  = 5'h02;
  localparam logic [ADDR_W-1:0] ADDR_RXST_L  = 5'h08;
  localparam logic [ADDR_W-1:0] ADDR_RXST_H  = 5'h09;
  localparam logic [ADDR_W-1:0] ADDR_RXND_L  = 5'h0A;
  localparam logic [ADDR_W-1:0] ADDR_RXND_H  = 5'h0B;
  localparam logic [ADDR_W-1:0] ADDR_BUF     = 5'h1A;
  localparam logic [ADDR_W-1:0] FIRST_SHARED = 5'h1B;
  localparam logic [ADDR_W-1:0] ADDR_CTRL    = 5'h1F;

  typedef enum logic [2:0] {
    OP_CTRL_RD  = 3'd0,
    OP_BUF_RD   = 3'd1,
    OP_CTRL_WR  = 3'd2,
    OP_BUF_WR   = 3'd3,
    OP_BIT_SET  = 3'd4,
    OP_BIT_CLR  = 3'd5,
    OP_SOFT_RST = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  // Write port command into the bank register store.
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } bank_wr_t;

  // Write port command into packet memory.
  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } pkt_wr_t;

endpackage

// ----- rtl/brbp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module brbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/brbp_exec.sv -----
// Execute stage: register state, pointers and the modify/writeback of one access.
module brbp_exec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  brbp_pkg::op_t                 op,
  input  logic [brbp_pkg::ADDR_W-1:0]   addr,
  input  logic [brbp_pkg::DATA_W-1:0]   wdata,
  input  logic [brbp_pkg::DATA_W-1:0]   bank_rd_data,
  input  logic [brbp_pkg::DATA_W-1:0]   pkt_rd_data,
  output logic [brbp_pkg::DATA_W-1:0]   result,
  output brbp_pkg::bank_wr_t            bank_wr,
  output brbp_pkg::pkt_wr_t             pkt_wr,
  output logic [brbp_pkg::BANK_W-1:0]   ctrl_bank,
  output logic [brbp_pkg::PTR_W-1:0]    read_ptr
);

  logic [brbp_pkg::DATA_W-1:0]    shared_r   [brbp_pkg::SHARED_COUNT];
  logic [brbp_pkg::DATA_W-1:0]    shared_nxt [brbp_pkg::SHARED_COUNT];
  logic [brbp_pkg::PTR_W-1:0]     read_ptr_r, read_ptr_nxt;
  logic [brbp_pkg::PTR_W-1:0]     write_ptr_r, write_ptr_nxt;
  logic [15:0]                    rx_start_r, rx_start_nxt;
  logic [15:0]                    rx_end_r, rx_end_nxt;
  logic [brbp_pkg::REG_DEPTH-1:0] valid_r, valid_nxt;

  logic                        is_shared, bank_ok, is_ptr, is_rp;
  logic [brbp_pkg::SH_IW-1:0]  sidx;
  logic [brbp_pkg::REG_AW-1:0] mem_idx;
  logic [15:0]                 ptr_sel, new_ptr16;
  logic [brbp_pkg::DATA_W-1:0] ptr_byte, bank_byte, reg_rd, wr_val;
  logic                        reg_we, bank_we, pkt_we, clear;

  function automatic logic [brbp_pkg::PTR_W-1:0] ptr_inc(
    input logic [brbp_pkg::PTR_W-1:0] p
  );
    if (p == brbp_pkg::PTR_W'(brbp_pkg::BUFFER_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Address decode
  assign ctrl_bank = shared_r[brbp_pkg::SHARED_COUNT-1][brbp_pkg::BANK_W-1:0];
  assign is_shared = (addr >= brbp_pkg::FIRST_SHARED);
  assign sidx      = brbp_pkg::SH_IW'(addr - brbp_pkg::FIRST_SHARED);
  assign bank_ok   = (int'(ctrl_bank) < brbp_pkg::BANK_COUNT);
  assign is_ptr    = (ctrl_bank == '0) && (addr < brbp_pkg::ADDR_PTR_END);
  assign is_rp     = (addr < brbp_pkg::ADDR_RP_END);
  assign mem_idx   = {ctrl_bank, addr};

  // Register read path; a bank entry not written since reset reads as zero
  assign ptr_sel   = is_rp ? 16'(read_ptr_r) : 16'(write_ptr_r);
  assign ptr_byte  = addr[0] ? ptr_sel[15:8] : ptr_sel[7:0];
  assign bank_byte = valid_r[mem_idx] ? bank_rd_data : '0;

  always_comb begin
    if (is_shared) begin
      reg_rd = shared_r[sidx];
    end else if (!bank_ok) begin
      reg_rd = '0;
    end else if (is_ptr) begin
      reg_rd = ptr_byte;
    end else begin
      reg_rd = bank_byte;
    end
  end

  // Modified write value and the pointer it assembles
  always_comb begin
    case (op)
      brbp_pkg::OP_BIT_SET: wr_val = reg_rd | wdata;
      brbp_pkg::OP_BIT_CLR: wr_val = reg_rd & ~wdata;
      default:              wr_val = wdata;
    endcase
  end

  assign new_ptr16 = addr[0] ? {wr_val, ptr_sel[7:0]} : {ptr_sel[15:8], wr_val};

  // Next state of one access
  always_comb begin
    shared_nxt    = shared_r;
    read_ptr_nxt  = read_ptr_r;
    write_ptr_nxt = write_ptr_r;
    rx_start_nxt  = rx_start_r;
    rx_end_nxt    = rx_end_r;
    valid_nxt     = valid_r;
    result        = '0;
    reg_we        = 1'b0;
    bank_we       = 1'b0;
    pkt_we        = 1'b0;
    clear         = 1'b0;

    case (op)
      brbp_pkg::OP_CTRL_RD: begin
        result = reg_rd;
      end
      brbp_pkg::OP_BUF_RD: begin
        if (addr == brbp_pkg::ADDR_BUF) begin
          result = pkt_rd_data;
          // receive ring: jump from the end back to the start
          if (16'(read_ptr_r) == rx_end_r) begin
            read_ptr_nxt = rx_start_r[brbp_pkg::PTR_W-1:0];
          end else begin
            read_ptr_nxt = ptr_inc(read_ptr_r);
          end
        end
      end
      brbp_pkg::OP_CTRL_WR, brbp_pkg::OP_BIT_SET, brbp_pkg::OP_BIT_CLR: begin
        reg_we = 1'b1;
      end
      brbp_pkg::OP_BUF_WR: begin
        if (addr == brbp_pkg::ADDR_BUF) begin
          pkt_we        = 1'b1;
          write_ptr_nxt = ptr_inc(write_ptr_r);
        end
      end
      brbp_pkg::OP_SOFT_RST: begin
        if (addr == brbp_pkg::ADDR_CTRL) begin
          clear = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Register writeback: shared, pointer bytes or the bank store
    if (reg_we) begin
      if (is_shared) begin
        shared_nxt[sidx] = wr_val;
      end else if (bank_ok) begin
        if (is_ptr) begin
          if (is_rp) begin
            read_ptr_nxt = new_ptr16[brbp_pkg::PTR_W-1:0];
          end else begin
            write_ptr_nxt = new_ptr16[brbp_pkg::PTR_W-1:0];
          end
        end else begin
          bank_we            = 1'b1;
          valid_nxt[mem_idx] = 1'b1;
          // copies of receive start and end for the buffer read path
          if (ctrl_bank == '0) begin
            case (addr)
              brbp_pkg::ADDR_RXST_L: rx_start_nxt[7:0]  = wr_val;
              brbp_pkg::ADDR_RXST_H: rx_start_nxt[15:8] = wr_val;
              brbp_pkg::ADDR_RXND_L: rx_end_nxt[7:0]    = wr_val;
              brbp_pkg::ADDR_RXND_H: rx_end_nxt[15:8]   = wr_val;
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // Memory write commands, committed only on the execute beat
  assign bank_wr.en   = go && bank_we;
  assign bank_wr.addr = mem_idx;
  assign bank_wr.data = wr_val;
  assign pkt_wr.en    = go && pkt_we;
  assign pkt_wr.addr  = write_ptr_r;
  assign pkt_wr.data  = wdata;

  assign read_ptr = read_ptr_r;

  // State registers; hard and soft reset clear everything but packet memory
  always_ff @(posedge clk) begin
    if (!rst_n || (go && clear)) begin
      for (int i = 0; i < brbp_pkg::SHARED_COUNT; i++) begin
        shared_r[i] <= '0;
      end
      read_ptr_r  <= '0;
      write_ptr_r <= '0;
      rx_start_r  <= '0;
      rx_end_r    <= '0;
      valid_r     <= '0;
    end else if (go) begin
      shared_r    <= shared_nxt;
      read_ptr_r  <= read_ptr_nxt;
      write_ptr_r <= write_ptr_nxt;
      rx_start_r  <= rx_start_nxt;
      rx_end_r    <= rx_end_nxt;
      valid_r     <= valid_nxt;
    end
  end

endmodule

// ----- rtl/banked_register_and_buffer_port_core.sv -----
// Top level: access sequencer, bank register store and packet memory.
//
//   channel | direction | ports                                          | fires on
//   in      | input     | in_op, in_reg_addr, in_wdata, in_end_of_frame  | in_valid & in_ready
//   out     | output    | out_rdata                                      | out_valid & out_ready
//
// An access has an accept beat, then an execute cycle. The accept beat issues
// the reads of the bank store and of packet memory; the execute cycle modifies,
// writes back and loads the output register. Both memories have one read and
// one write port. While the output register is full and not taken, the execute
// cycle waits. Reset clears the registers at once; bank store entries read as
// zero through per-entry valid bits, so there is no clearing pass. in_end_of_frame
// is taken with the beat and has no effect, since each access stands on its own.
module banked_register_and_buffer_port_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_op,
  input  logic [brbp_pkg::ADDR_W-1:0] in_reg_addr,
  input  logic [brbp_pkg::DATA_W-1:0] in_wdata,
  input  logic                        in_end_of_frame,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [brbp_pkg::DATA_W-1:0] out_rdata
);

  `include "banked_register_and_buffer_port_core_macros.svh"

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                      state_r;
  logic                        out_valid_r;
  logic [brbp_pkg::DATA_W-1:0] out_rdata_r;
  brbp_pkg::op_t               op_r;
  logic [brbp_pkg::ADDR_W-1:0] addr_r;
  logic [brbp_pkg::DATA_W-1:0] wdata_r;

  logic                        accept, go;
  logic [brbp_pkg::DATA_W-1:0] bank_rd_data, pkt_rd_data, result;
  logic [brbp_pkg::BANK_W-1:0] ctrl_bank;
  logic [brbp_pkg::PTR_W-1:0]  read_ptr;
  brbp_pkg::bank_wr_t          bank_wr;
  brbp_pkg::pkt_wr_t           pkt_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign go        = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_rdata = out_rdata_r;

  // Bank register store, read at the accept beat
  brbp_ram #(
    .WIDTH (brbp_pkg::DATA_W),
    .DEPTH (brbp_pkg::REG_DEPTH)
  ) u_bank_ram (
    .clk     (clk),
    .wr_en   (bank_wr.en),
    .wr_addr (bank_wr.addr),
    .wr_data (bank_wr.data),
    .rd_en   (accept),
    .rd_addr ({ctrl_bank, in_reg_addr}),
    .rd_data (bank_rd_data)
  );

  // Packet memory, read at the read pointer on the accept beat
  brbp_ram #(
    .WIDTH (brbp_pkg::DATA_W),
    .DEPTH (brbp_pkg::BUFFER_DEPTH)
  ) u_pkt_ram (
    .clk     (clk),
    .wr_en   (pkt_wr.en),
    .wr_addr (pkt_wr.addr),
    .wr_data (pkt_wr.data),
    .rd_en   (accept),
    .rd_addr (read_ptr),
    .rd_data (pkt_rd_data)
  );

  brbp_exec u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .op           (op_r),
    .addr         (addr_r),
    .wdata        (wdata_r),
    .bank_rd_data (bank_rd_data),
    .pkt_rd_data  (pkt_rd_data),
    .result       (result),
    .bank_wr      (bank_wr),
    .pkt_wr       (pkt_wr),
    .ctrl_bank    (ctrl_bank),
    .read_ptr     (read_ptr)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            out_valid_r <= 1'b1;
            out_rdata_r <= result;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= brbp_pkg::op_t'(in_op);
      addr_r  <= in_reg_addr;
      wdata_r <= in_wdata;
    end
  end

  // One access in flight: an accept is always followed by the execute cycle
  `BRBP_ASSERT_NEXT(a_one_in_flight, accept, (state_r == S_EXEC) && !in_ready)
  // The execute cycle waits while the output register is held
  `BRBP_ASSERT_NEXT(a_exec_waits, (state_r == S_EXEC) && !go, (state_r == S_EXEC) && out_valid)
  // Memory writes happen only on the execute beat
  `BRBP_ASSERT(a_write_on_go, !(bank_wr.en || pkt_wr.en) || go)

endmodule
